### src/adsr_env_pkg.sv
// Shared constants and types for the linear ADSR envelope level core.
package adsr_env_pkg;

  localparam int unsigned TIME_BITS_DEF       = 24;
  localparam int unsigned LEVEL_FRAC_BITS_DEF = 15;
  localparam int unsigned SEG_W               = 3;
  localparam int unsigned CFG_IDX_W           = 3;

  typedef enum logic [SEG_W-1:0] {
    SEG_ATTACK  = 3'd0,
    SEG_DECAY   = 3'd1,
    SEG_SUSTAIN = 3'd2,
    SEG_RELEASE = 3'd3,
    SEG_DONE    = 3'd4
  } seg_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3,
    REG_LEVEL   = 3'd4
  } cfg_reg_e;

endpackage

### src/adsr_env_cfg.sv
// Configuration registers and the segment end times derived from them.
module adsr_env_cfg
  import adsr_env_pkg::*;
#(
  parameter int unsigned TIME_BITS       = TIME_BITS_DEF,
  parameter int unsigned LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
  localparam int unsigned CFG_W = (TIME_BITS > LEVEL_FRAC_BITS + 1) ?
                                  TIME_BITS : LEVEL_FRAC_BITS + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  output logic [TIME_BITS-1:0]         attack_o,
  output logic [TIME_BITS-1:0]         decay_o,
  output logic [TIME_BITS-1:0]         release_o,
  output logic [TIME_BITS+1:0]         end_d_o,
  output logic [TIME_BITS+1:0]         end_s_o,
  output logic [TIME_BITS+1:0]         end_r_o,
  output logic [LEVEL_FRAC_BITS:0]     sustain_lvl_o
);

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned EW = TIME_BITS + 2;
  localparam int unsigned LW = LEVEL_FRAC_BITS + 1;
  localparam logic [LW-1:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  logic [TB-1:0] attack_q, decay_q, sustain_q, release_q;
  logic [LW-1:0] level_q;
  logic [EW-1:0] end_d_q, end_s_q, end_r_q;
  logic [LW-1:0] sl_sat_q;
  logic [EW-1:0] sum_ad, sum_sr, end_s_d, end_r_d;
  logic [LW-1:0] sl_sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      decay_q   <= '0;
      sustain_q <= '0;
      release_q <= '0;
      level_q   <= FULL;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ATTACK:  attack_q  <= cfg_data_i[TB-1:0];
        REG_DECAY:   decay_q   <= cfg_data_i[TB-1:0];
        REG_SUSTAIN: sustain_q <= cfg_data_i[TB-1:0];
        REG_RELEASE: release_q <= cfg_data_i[TB-1:0];
        REG_LEVEL:   level_q   <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  assign sum_ad   = {2'b00, attack_q} + {2'b00, decay_q};
  assign sum_sr   = {2'b00, sustain_q} + {2'b00, release_q};
  assign end_s_d  = sum_ad + {2'b00, sustain_q};
  assign end_r_d  = sum_ad + sum_sr;
  assign sl_sat_d = (level_q > FULL) ? FULL : level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_d_q  <= '0;
      end_s_q  <= '0;
      end_r_q  <= '0;
      sl_sat_q <= FULL;
    end else begin
      end_d_q  <= sum_ad;
      end_s_q  <= end_s_d;
      end_r_q  <= end_r_d;
      sl_sat_q <= sl_sat_d;
    end
  end

  assign attack_o      = attack_q;
  assign decay_o       = decay_q;
  assign release_o     = release_q;
  assign end_d_o       = end_d_q;
  assign end_s_o       = end_s_q;
  assign end_r_o       = end_r_q;
  assign sustain_lvl_o = sl_sat_q;

endmodule

### src/adsr_env_front.sv
// Front pipeline: input capture, segment decode and ramp numerator multiply.
module adsr_env_front
  import adsr_env_pkg::*;
#(
  parameter int unsigned TIME_BITS       = TIME_BITS_DEF,
  parameter int unsigned LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [TIME_BITS-1:0]                   attack_i,
  input  logic [TIME_BITS-1:0]                   decay_i,
  input  logic [TIME_BITS-1:0]                   release_i,
  input  logic [TIME_BITS+1:0]                   end_d_i,
  input  logic [TIME_BITS+1:0]                   end_s_i,
  input  logic [TIME_BITS+1:0]                   end_r_i,
  input  logic [LEVEL_FRAC_BITS:0]               sustain_lvl_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [TIME_BITS+1:0]                   elapsed_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [TIME_BITS+LEVEL_FRAC_BITS-1:0]   num_o,
  output logic [TIME_BITS-1:0]                   div_o,
  output seg_e                                   seg_o,
  output logic [LEVEL_FRAC_BITS:0]               base_o,
  output logic                                   add_o
);

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned EW = TIME_BITS + 2;
  localparam int unsigned LW = LEVEL_FRAC_BITS + 1;
  localparam int unsigned NW = TIME_BITS + LEVEL_FRAC_BITS;
  localparam logic [LW-1:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  logic          v1_q, v2_q, v3_q;
  logic          en1, en2, en3;
  logic [EW-1:0] t1_q;

  seg_e          seg2_q, seg_d;
  logic [TB-1:0] off2_q, off_d;
  logic [LW-1:0] fac2_q, fac_d;
  logic [TB-1:0] div2_q, div_d;
  logic [LW-1:0] base2_q, base_d;
  logic          add2_q, add_d;
  logic [EW-1:0] diff_a, diff_d, diff_s;

  logic [LW+TB-1:0] prod;
  logic [NW-1:0]    num3_q;
  logic [TB-1:0]    div3_q;
  seg_e             seg3_q;
  logic [LW-1:0]    base3_q;
  logic             add3_q;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      t1_q <= elapsed_i;
    end
  end

  assign diff_a = t1_q - {2'b00, attack_i};
  assign diff_d = t1_q - end_d_i;
  assign diff_s = t1_q - end_s_i;

  always_comb begin
    seg_d  = SEG_DONE;
    off_d  = '0;
    fac_d  = '0;
    div_d  = TB'(1);
    base_d = '0;
    add_d  = 1'b0;
    priority if (t1_q < {2'b00, attack_i}) begin
      seg_d  = SEG_ATTACK;
      off_d  = t1_q[TB-1:0];
      fac_d  = FULL;
      div_d  = attack_i;
      add_d  = 1'b1;
    end else if (t1_q < end_d_i) begin
      seg_d  = SEG_DECAY;
      off_d  = diff_a[TB-1:0];
      fac_d  = FULL - sustain_lvl_i;
      div_d  = decay_i;
      base_d = FULL;
    end else if (t1_q < end_s_i) begin
      seg_d  = SEG_SUSTAIN;
      off_d  = diff_d[TB-1:0] & '0;
      base_d = sustain_lvl_i;
    end else if (t1_q < end_r_i) begin
      seg_d  = SEG_RELEASE;
      off_d  = diff_s[TB-1:0];
      fac_d  = sustain_lvl_i;
      div_d  = release_i;
      base_d = sustain_lvl_i;
    end else begin
      seg_d  = SEG_DONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      seg2_q  <= seg_d;
      off2_q  <= off_d;
      fac2_q  <= fac_d;
      div2_q  <= div_d;
      base2_q <= base_d;
      add2_q  <= add_d;
    end
  end

  assign prod = {{TB{1'b0}}, fac2_q} * {{LW{1'b0}}, off2_q};

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      num3_q  <= prod[NW-1:0];
      div3_q  <= div2_q;
      seg3_q  <= seg2_q;
      base3_q <= base2_q;
      add3_q  <= add2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign num_o       = num3_q;
  assign div_o       = div3_q;
  assign seg_o       = seg3_q;
  assign base_o      = base3_q;
  assign add_o       = add3_q;

endmodule

### src/adsr_env_div.sv
// Pipelined restoring divider that retires one quotient bit per stage.
module adsr_env_div
  import adsr_env_pkg::*;
#(
  parameter int unsigned TIME_BITS       = TIME_BITS_DEF,
  parameter int unsigned LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
  parameter int unsigned SIDE_W          = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [TIME_BITS+LEVEL_FRAC_BITS-1:0] num_i,
  input  logic [TIME_BITS-1:0]                 div_i,
  input  logic [SIDE_W-1:0]                    side_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [LEVEL_FRAC_BITS-1:0]           quo_o,
  output logic [SIDE_W-1:0]                    side_o
);

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned F  = LEVEL_FRAC_BITS;

  logic          vld_w  [F+1];
  logic          rdy_w  [F+1];
  logic [TB-1:0] rem_w  [F+1];
  logic [F-1:0]  low_w  [F+1];
  logic [F-1:0]  quo_w  [F+1];
  logic [TB-1:0] div_w  [F+1];
  logic [SIDE_W-1:0] side_w [F+1];

  assign vld_w[0]  = in_valid_i;
  assign rem_w[0]  = num_i[TB+F-1:F];
  assign low_w[0]  = num_i[F-1:0];
  assign quo_w[0]  = '0;
  assign div_w[0]  = div_i;
  assign side_w[0] = side_i;
  assign in_ready_o = rdy_w[0];
  assign rdy_w[F]   = out_ready_i;

  for (genvar k = 0; k < F; k++) begin : g_stage
    logic              vld_q;
    logic [TB-1:0]     rem_q;
    logic [F-1:0]      low_q;
    logic [F-1:0]      quo_q;
    logic [TB-1:0]     div_q;
    logic [SIDE_W-1:0] side_q;
    logic              en;
    logic [TB:0]       trial, diff;
    logic              ge;
    logic [TB-1:0]     rem_n;

    assign en       = !vld_q || rdy_w[k+1];
    assign rdy_w[k] = en;
    assign trial    = {rem_w[k], low_w[k][F-1]};
    assign diff     = trial - {1'b0, div_w[k]};
    assign ge       = trial >= {1'b0, div_w[k]};
    assign rem_n    = ge ? diff[TB-1:0] : trial[TB-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en && vld_w[k]) begin
        rem_q  <= rem_n;
        low_q  <= {low_w[k][F-2:0], 1'b0};
        quo_q  <= {quo_w[k][F-2:0], ge};
        div_q  <= div_w[k];
        side_q <= side_w[k];
      end
    end

    assign vld_w[k+1]  = vld_q;
    assign rem_w[k+1]  = rem_q;
    assign low_w[k+1]  = low_q;
    assign quo_w[k+1]  = quo_q;
    assign div_w[k+1]  = div_q;
    assign side_w[k+1] = side_q;
  end

  assign out_valid_o = vld_w[F];
  assign quo_o       = quo_w[F];
  assign side_o      = side_w[F];

endmodule

### src/adsr_envelope_level_core.sv
// Linear ADSR envelope level core: top level with the output register stage.
// An accepted input transaction passes through the front pipeline, the one-bit-per-stage
// divider and the output register stage before its result is valid.
// Throughput: one transaction per cycle while out_ready_i is held high; every stage stalls on its own.
// Reset: all valid bits clear, timing registers reset to 0, sustain level to full scale.
// A configuration write lands in its register, then in the registered segment end times.
module adsr_envelope_level_core
  import adsr_env_pkg::*;
#(
  parameter int unsigned TIME_BITS       = TIME_BITS_DEF,
  parameter int unsigned LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
  localparam int unsigned CFG_W = (TIME_BITS > LEVEL_FRAC_BITS + 1) ?
                                  TIME_BITS : LEVEL_FRAC_BITS + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [TIME_BITS+1:0]       elapsed_ticks_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [LEVEL_FRAC_BITS:0]   level_o,
  output logic [SEG_W-1:0]           segment_o
);

  localparam int unsigned TB     = TIME_BITS;
  localparam int unsigned EW     = TIME_BITS + 2;
  localparam int unsigned F      = LEVEL_FRAC_BITS;
  localparam int unsigned LW     = LEVEL_FRAC_BITS + 1;
  localparam int unsigned NW     = TIME_BITS + LEVEL_FRAC_BITS;
  localparam int unsigned SIDE_W = SEG_W + 1 + LW;

  logic [TB-1:0] attack, decay, release_len;
  logic [EW-1:0] end_d, end_s, end_r;
  logic [LW-1:0] sustain_lvl;

  logic          fr_valid, fr_ready;
  logic [NW-1:0] fr_num;
  logic [TB-1:0] fr_div;
  seg_e          fr_seg;
  logic [LW-1:0] fr_base;
  logic          fr_add;
  logic [SIDE_W-1:0] fr_side;

  logic              dv_valid, dv_ready;
  logic [F-1:0]      dv_quo;
  logic [SIDE_W-1:0] dv_side;
  seg_e              dv_seg;
  logic              dv_add;
  logic [LW-1:0]     dv_base;

  logic          out_vld_q, out_en;
  logic [LW-1:0] level_q, level_d;
  seg_e          seg_q;

  adsr_env_cfg #(
    .TIME_BITS       (TIME_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .attack_o      (attack),
    .decay_o       (decay),
    .release_o     (release_len),
    .end_d_o       (end_d),
    .end_s_o       (end_s),
    .end_r_o       (end_r),
    .sustain_lvl_o (sustain_lvl)
  );

  adsr_env_front #(
    .TIME_BITS       (TIME_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .attack_i      (attack),
    .decay_i       (decay),
    .release_i     (release_len),
    .end_d_i       (end_d),
    .end_s_i       (end_s),
    .end_r_i       (end_r),
    .sustain_lvl_i (sustain_lvl),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .elapsed_i     (elapsed_ticks_i),
    .out_valid_o   (fr_valid),
    .out_ready_i   (fr_ready),
    .num_o         (fr_num),
    .div_o         (fr_div),
    .seg_o         (fr_seg),
    .base_o        (fr_base),
    .add_o         (fr_add)
  );

  assign fr_side = {fr_seg, fr_add, fr_base};

  adsr_env_div #(
    .TIME_BITS       (TIME_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
    .SIDE_W          (SIDE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .num_i       (fr_num),
    .div_i       (fr_div),
    .side_i      (fr_side),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .quo_o       (dv_quo),
    .side_o      (dv_side)
  );

  assign dv_seg  = seg_e'(dv_side[SIDE_W-1 -: SEG_W]);
  assign dv_add  = dv_side[LW];
  assign dv_base = dv_side[LW-1:0];

  assign out_en   = !out_vld_q || out_ready_i;
  assign dv_ready = out_en;
  assign level_d  = dv_add ? {1'b0, dv_quo} : (dv_base - {1'b0, dv_quo});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && dv_valid) begin
      level_q <= level_d;
      seg_q   <= dv_seg;
    end
  end

  assign out_valid_o = out_vld_q;
  assign level_o     = level_q;
  assign segment_o   = seg_q;

endmodule

### sim/adsr_envelope_level_checker.sv
`timescale 1ns / 1ps
// Checker for the ADSR envelope level core: predicts each result and compares it.
module adsr_envelope_level_checker
  import adsr_env_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [TIME_BITS_DEF-1:0]         cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [TIME_BITS_DEF+1:0]         elapsed_ticks_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [LEVEL_FRAC_BITS_DEF:0]     level_i,
  input  logic [SEG_W-1:0]                 segment_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int unsigned FRAC = LEVEL_FRAC_BITS_DEF;
  localparam int unsigned TB   = TIME_BITS_DEF;
  localparam logic [63:0] FULL_SCALE = 64'd1 << FRAC;

  typedef struct packed {
    logic [FRAC:0] level;
    seg_e          segment;
  } envelope_t;

  logic [TB-1:0] attack_len  = '0;
  logic [TB-1:0] decay_len   = '0;
  logic [TB-1:0] hold_len    = '0;
  logic [TB-1:0] release_len = '0;
  logic [FRAC:0] sustain_lvl = FULL_SCALE[FRAC:0];

  envelope_t expected_envelope_q[$];

  function automatic envelope_t envelope_at(input logic [TB+1:0] t);
    logic [63:0] tt;
    logic [63:0] sl;
    logic [63:0] end_a;
    logic [63:0] end_d;
    logic [63:0] end_s;
    logic [63:0] end_r;
    logic [63:0] lvl;
    envelope_t   e;
    tt    = 64'(t);
    sl    = (64'(sustain_lvl) > FULL_SCALE) ? FULL_SCALE : 64'(sustain_lvl);
    end_a = 64'(attack_len);
    end_d = end_a + 64'(decay_len);
    end_s = end_d + 64'(hold_len);
    end_r = end_s + 64'(release_len);
    if (tt < end_a) begin
      lvl       = (tt << FRAC) / end_a;
      e.segment = SEG_ATTACK;
    end else if (tt < end_d) begin
      lvl       = FULL_SCALE - ((FULL_SCALE - sl) * (tt - end_a)) / 64'(decay_len);
      e.segment = SEG_DECAY;
    end else if (tt < end_s) begin
      lvl       = sl;
      e.segment = SEG_SUSTAIN;
    end else if (tt < end_r) begin
      lvl       = sl - (sl * (tt - end_s)) / 64'(release_len);
      e.segment = SEG_RELEASE;
    end else begin
      lvl       = '0;
      e.segment = SEG_DONE;
    end
    e.level = lvl[FRAC:0];
    return e;
  endfunction

  always @(posedge clk_i) begin
    envelope_t exp_env;
    if (!rst_ni) begin
      attack_len  = '0;
      decay_len   = '0;
      hold_len    = '0;
      release_len = '0;
      sustain_lvl = FULL_SCALE[FRAC:0];
      expected_envelope_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_envelope_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual level %0d segment %0d",
                   $time, level_i, segment_i);
          fail_count_o++;
        end else begin
          exp_env = expected_envelope_q.pop_front();
          if (level_i !== exp_env.level) begin
            $display("%0t: level mismatch, expected %0d, actual %0d",
                     $time, exp_env.level, level_i);
            fail_count_o++;
          end
          if (segment_i !== exp_env.segment) begin
            $display("%0t: segment mismatch, expected %0d, actual %0d",
                     $time, exp_env.segment, segment_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_envelope_q.push_back(envelope_at(elapsed_ticks_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATTACK:  attack_len  = cfg_data_i;
          REG_DECAY:   decay_len   = cfg_data_i;
          REG_SUSTAIN: hold_len    = cfg_data_i;
          REG_RELEASE: release_len = cfg_data_i;
          REG_LEVEL:   sustain_lvl = cfg_data_i[FRAC:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_envelope_q.size();
  end

endmodule

### sim/adsr_envelope_level_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the ADSR envelope level core: stimulus, flow control and verdict.
module adsr_envelope_level_core_test;
  import adsr_env_pkg::*;

  localparam int unsigned CFG_W = (TIME_BITS_DEF > LEVEL_FRAC_BITS_DEF + 1) ?
                                  TIME_BITS_DEF : LEVEL_FRAC_BITS_DEF + 1;
  localparam int unsigned LEVEL_W         = LEVEL_FRAC_BITS_DEF + 1;
  localparam int unsigned FULL            = 1 << LEVEL_FRAC_BITS_DEF;
  localparam int unsigned LATENCY         = LEVEL_FRAC_BITS_DEF + 3;
  localparam int unsigned NUM_REGS        = 5;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS     = 123;
  localparam logic [TIME_BITS_DEF-1:0] TICKS_MAX   = '1;
  localparam logic [TIME_BITS_DEF+1:0] ELAPSED_MAX = '1;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [CFG_IDX_W-1:0]           cfg_idx;
  logic [CFG_W-1:0]               cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [TIME_BITS_DEF+1:0]       elapsed;
  logic                           out_valid;
  logic                           out_ready;
  logic [LEVEL_FRAC_BITS_DEF:0]   level;
  logic [SEG_W-1:0]               segment;
  int                             fail_count;
  int                             pending;

  bit      sender_no_gaps;
  bit      hold_off_req;
  longint  seg_end [4];

  adsr_envelope_level_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .elapsed_ticks_i (elapsed),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .level_o         (level),
    .segment_o       (segment)
  );

  adsr_envelope_level_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .elapsed_ticks_i (elapsed),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .level_i         (level),
    .segment_i       (segment),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic program_envelope(input logic [TIME_BITS_DEF-1:0] a,
                                  input logic [TIME_BITS_DEF-1:0] d,
                                  input logic [TIME_BITS_DEF-1:0] s,
                                  input logic [TIME_BITS_DEF-1:0] r,
                                  input logic [CFG_W-1:0] lvl_data);
    write_reg(REG_ATTACK, CFG_W'(a));
    write_reg(REG_DECAY, CFG_W'(d));
    write_reg(REG_SUSTAIN, CFG_W'(s));
    write_reg(REG_RELEASE, CFG_W'(r));
    write_reg(REG_LEVEL, lvl_data);
    cfg_we <= 1'b0;
    seg_end[0] = longint'(a);
    seg_end[1] = seg_end[0] + longint'(d);
    seg_end[2] = seg_end[1] + longint'(s);
    seg_end[3] = seg_end[2] + longint'(r);
    repeat (2) @(negedge clk);
  endtask

  task automatic send_elapsed(input logic [TIME_BITS_DEF+1:0] t);
    int unsigned gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    elapsed  <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  function automatic logic [TIME_BITS_DEF-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3:    return TIME_BITS_DEF'($urandom_range(1, 16));
      4, 5, 6: return TIME_BITS_DEF'($urandom_range(1, 4095));
      7:       return TICKS_MAX;
      default: return TIME_BITS_DEF'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_sustain_data();
    logic [CFG_W-1:0] d;
    d = CFG_W'($urandom);
    case ($urandom_range(0, 5))
      0:       d[LEVEL_W-1:0] = '0;
      1:       d[LEVEL_W-1:0] = LEVEL_W'(FULL);
      2:       d[LEVEL_W-1:0] = LEVEL_W'($urandom_range(FULL + 1, (1 << LEVEL_W) - 1));
      default: d[LEVEL_W-1:0] = LEVEL_W'($urandom_range(0, FULL));
    endcase
    if ($urandom_range(0, 1) == 0) d[CFG_W-1:LEVEL_W] = '0;
    return d;
  endfunction

  function automatic logic [TIME_BITS_DEF+1:0] pick_elapsed();
    longint t;
    case ($urandom_range(0, 9))
      0, 1:    t = longint'($urandom) & longint'(ELAPSED_MAX);
      2, 3:    t = seg_end[$urandom_range(0, 3)] + longint'($urandom_range(0, 4)) - 2;
      default: t = longint'($urandom_range(0, seg_end[3] + seg_end[3] / 8 + 4));
    endcase
    if (t < 0) t = 0;
    if (t > longint'(ELAPSED_MAX)) t = longint'(ELAPSED_MAX);
    return t[TIME_BITS_DEF+1:0];
  endfunction

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_ATTACK;
    cfg_data       = '0;
    in_valid       = 1'b0;
    elapsed        = '0;
    sender_no_gaps = 1'b0;
    hold_off_req   = 1'b0;
    seg_end        = '{default: 0};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), '1);
    end
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
    send_elapsed('0);
    send_elapsed(ELAPSED_MAX);
    drain_results();

    program_envelope(100, 200, 300, 400, CFG_W'(FULL / 2));
    send_elapsed(0);
    send_elapsed(1);
    send_elapsed(99);
    send_elapsed(100);
    send_elapsed(101);
    send_elapsed(299);
    send_elapsed(300);
    send_elapsed(599);
    send_elapsed(600);
    send_elapsed(601);
    send_elapsed(999);
    send_elapsed(1000);
    drain_results();

    program_envelope(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, '1);
    send_elapsed(0);
    send_elapsed((TIME_BITS_DEF+2)'(TICKS_MAX - 1));
    send_elapsed((TIME_BITS_DEF+2)'(TICKS_MAX));
    send_elapsed((TIME_BITS_DEF+2)'(TICKS_MAX * 2));
    send_elapsed((TIME_BITS_DEF+2)'(TICKS_MAX * 3 - 1));
    send_elapsed((TIME_BITS_DEF+2)'(TICKS_MAX * 4 - 1));
    send_elapsed((TIME_BITS_DEF+2)'(TICKS_MAX * 4));
    send_elapsed(ELAPSED_MAX);
    drain_results();

    program_envelope(0, 0, 5, 0, '0);
    send_elapsed(0);
    send_elapsed(4);
    send_elapsed(5);
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_envelope(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                       pick_sustain_data());
      sender_no_gaps = (p == 1) || ($urandom_range(0, 3) == 0);
      if (p == 1) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_elapsed(pick_elapsed());
      end
      drain_results();
    end

    repeat (LATENCY + 2) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned results;
    bit          calm;
    out_ready = 1'b0;
    results   = 0;
    calm      = 1'b0;
    @(posedge rst_n);
    forever begin
      if (results % 97 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 11);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results++;
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
src/adsr_env_pkg.sv
src/adsr_env_cfg.sv
src/adsr_env_front.sv
src/adsr_env_div.sv
src/adsr_envelope_level_core.sv
sim/adsr_envelope_level_checker.sv
sim/adsr_envelope_level_core_test.sv
